FILE: src/sse_pkg.sv
package sse_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_PLACE_BITS = 16;

  localparam int ACTION_W = 2;
  localparam int PLACE_W  = 16;
  localparam int RND_W    = 16;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_PICK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_upd;
    logic ins_init;
    logic ins_rd;
    logic ins_wr;
    logic ins_put;
    logic rem_init;
    logic rem_rd;
    logic rem_wr;
    logic div_step;
    logic pick_rd;
    logic fin;
  } sse_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                srch_more;
    logic                found;
    logic                full;
    logic                empty;
    logic                ins_any;
    logic                ins_more;
    logic                rem_any;
    logic                rem_more;
    logic                div_last;
  } sse_sts_t;

endpackage

FILE: src/sorted_set_engine_unit.sv
// One word at a time: busy is high from acceptance until the result strobe; a new word
// is taken only while busy is low. A search step reads and compares one entry (at most
// log2(count)+1 steps); insert and remove shift entries by a read and write each, and
// insert then places its entry. Pick on a non-empty set runs a 16-step modulo and a read.
// The result is on the out_ ports for one cycle with out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the set; stored entries are not cleared.
module sorted_set_engine_unit
  import sse_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int PLACE_BITS = DEF_PLACE_BITS
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [PLACE_W-1:0]  in_place,
  input  logic [RND_W-1:0]    in_random_value,
  output logic                out_valid,
  output logic                out_found,
  output logic [POS_W-1:0]    out_position,
  output logic [PLACE_W-1:0]  out_picked_place,
  output logic [CNT_W-1:0]    out_count_after,
  output logic [STATUS_W-1:0] out_status
);

  sse_cmd_t cmd;
  sse_sts_t sts;

  sse_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sse_datapath #(
    .CAPACITY   (CAPACITY),
    .PLACE_BITS (PLACE_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_place         (in_place),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_position     (out_position),
    .out_picked_place (out_picked_place),
    .out_count_after  (out_count_after),
    .out_status       (out_status)
  );

endmodule

FILE: src/sse_ctrl.sv
module sse_ctrl
  import sse_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  sse_sts_t sts,
  output sse_cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_SRCH_RD  = 4'd2;
  localparam logic [3:0] S_SRCH_CMP = 4'd3;
  localparam logic [3:0] S_DECIDE   = 4'd4;
  localparam logic [3:0] S_INS_RD   = 4'd5;
  localparam logic [3:0] S_INS_WR   = 4'd6;
  localparam logic [3:0] S_INS_PUT  = 4'd7;
  localparam logic [3:0] S_REM_RD   = 4'd8;
  localparam logic [3:0] S_REM_WR   = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_PICK_RD  = 4'd11;
  localparam logic [3:0] S_FIN      = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.action == ACT_PICK) begin
          state_nxt = sts.empty ? S_FIN : S_DIV;
        end else if (sts.srch_more) begin
          state_nxt = S_SRCH_RD;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_SRCH_RD: begin
        cmd.srch_rd = 1'b1;
        state_nxt   = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_DISPATCH;
      end
      S_DECIDE: begin
        state_nxt = S_FIN;
        if (sts.action == ACT_INSERT && !sts.found && !sts.full) begin
          cmd.ins_init = 1'b1;
          state_nxt    = sts.ins_any ? S_INS_RD : S_INS_PUT;
        end else if (sts.action == ACT_REMOVE && sts.found) begin
          cmd.rem_init = 1'b1;
          state_nxt    = sts.rem_any ? S_REM_RD : S_FIN;
        end
      end
      S_INS_RD: begin
        cmd.ins_rd = 1'b1;
        state_nxt  = S_INS_WR;
      end
      S_INS_WR: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = sts.ins_more ? S_INS_RD : S_INS_PUT;
      end
      S_INS_PUT: begin
        cmd.ins_put = 1'b1;
        state_nxt   = S_FIN;
      end
      S_REM_RD: begin
        cmd.rem_rd = 1'b1;
        state_nxt  = S_REM_WR;
      end
      S_REM_WR: begin
        cmd.rem_wr = 1'b1;
        state_nxt  = sts.rem_more ? S_REM_RD : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_PICK_RD;
        end
      end
      S_PICK_RD: begin
        cmd.pick_rd = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/sse_datapath.sv
module sse_datapath
  import sse_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int PLACE_BITS = DEF_PLACE_BITS
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  sse_cmd_t            cmd,
  output sse_sts_t            sts,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [PLACE_W-1:0]  in_place,
  input  logic [RND_W-1:0]    in_random_value,
  output logic                out_valid,
  output logic                out_found,
  output logic [POS_W-1:0]    out_position,
  output logic [PLACE_W-1:0]  out_picked_place,
  output logic [CNT_W-1:0]    out_count_after,
  output logic [STATUS_W-1:0] out_status
);

  localparam int IDX_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int DC_W  = $clog2(RND_W);
  localparam logic [IDX_W-1:0] CAP_IDX = IDX_W'(CAPACITY);

  logic [PLACE_BITS-1:0] mem [CAPACITY];

  logic [ACTION_W-1:0]   action_r;
  logic [PLACE_BITS-1:0] place_r;
  logic [RND_W-1:0]      rnd_r;
  logic [IDX_W-1:0]      count_r;
  logic [IDX_W-1:0]      lo_r;
  logic [IDX_W-1:0]      hi_r;
  logic                  eq_r;
  logic [IDX_W-1:0]      i_r;
  logic [IDX_W-1:0]      rem_r;
  logic [DC_W-1:0]       dcnt_r;
  logic [PLACE_BITS-1:0] rd_data_r;

  logic                  out_valid_r;
  logic                  out_found_r;
  logic [POS_W-1:0]      out_position_r;
  logic [PLACE_W-1:0]    out_picked_place_r;
  logic [CNT_W-1:0]      out_count_after_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic [PLACE_W+PLACE_BITS-1:0] place_ext;
  logic [PLACE_W+PLACE_BITS-1:0] picked_ext;
  logic [IDX_W:0]        mid_sum;
  logic [IDX_W-1:0]      mid;
  logic [IDX_W:0]        i_plus1;
  logic [IDX_W:0]        i_plus2;
  logic [IDX_W:0]        lo_plus1;
  logic [IDX_W-1:0]      i_minus1;
  logic [IDX_W:0]        div_try;
  logic [IDX_W:0]        div_sub;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [PLACE_BITS-1:0] wr_data;
  logic                  grow;
  logic                  shrink;
  logic [IDX_W-1:0]      count_nxt;
  logic [POS_W+IDX_W-1:0] pos_ext;
  logic [CNT_W+IDX_W-1:0] cnt_ext;

  assign place_ext = {{PLACE_BITS{1'b0}}, in_place};
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[IDX_W:1];
  assign i_plus1   = {1'b0, i_r} + {{IDX_W{1'b0}}, 1'b1};
  assign i_plus2   = {1'b0, i_r} + {{(IDX_W-1){1'b0}}, 2'd2};
  assign lo_plus1  = {1'b0, lo_r} + {{IDX_W{1'b0}}, 1'b1};
  assign i_minus1  = i_r - {{(IDX_W-1){1'b0}}, 1'b1};
  assign div_try   = {rem_r, rnd_r[RND_W-1]};
  assign div_sub   = div_try - {1'b0, count_r};

  assign sts.action    = action_r;
  assign sts.srch_more = (lo_r < hi_r);
  assign sts.found     = eq_r;
  assign sts.full      = (count_r >= CAP_IDX);
  assign sts.empty     = (count_r == '0);
  assign sts.ins_any   = (count_r != lo_r);
  assign sts.ins_more  = (i_minus1 != lo_r);
  assign sts.rem_any   = (lo_plus1 < {1'b0, count_r});
  assign sts.rem_more  = (i_plus2 < {1'b0, count_r});
  assign sts.div_last  = (dcnt_r == '0);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = mid[AW-1:0];
    if (cmd.ins_rd) begin
      rd_addr = i_minus1[AW-1:0];
    end else if (cmd.rem_rd) begin
      rd_addr = i_plus1[AW-1:0];
    end else if (cmd.pick_rd) begin
      rd_addr = rem_r[AW-1:0];
    end else if (!cmd.srch_rd) begin
      rd_en = 1'b0;
    end
  end

  always_comb begin
    wr_en   = cmd.ins_wr | cmd.rem_wr | cmd.ins_put;
    wr_addr = i_r[AW-1:0];
    wr_data = rd_data_r;
    if (cmd.ins_put) begin
      wr_addr = lo_r[AW-1:0];
      wr_data = place_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      place_r  <= place_ext[PLACE_BITS-1:0];
      rnd_r    <= in_random_value;
      lo_r     <= '0;
      hi_r     <= count_r;
      eq_r     <= 1'b0;
      rem_r    <= '0;
      dcnt_r   <= DC_W'(RND_W - 1);
    end
    if (cmd.srch_upd) begin
      if (rd_data_r < place_r) begin
        lo_r <= mid + {{(IDX_W-1){1'b0}}, 1'b1};
      end else begin
        hi_r <= mid;
        eq_r <= (rd_data_r == place_r);
      end
    end
    if (cmd.ins_init) begin
      i_r <= count_r;
    end else if (cmd.rem_init) begin
      i_r <= lo_r;
    end else if (cmd.ins_wr) begin
      i_r <= i_minus1;
    end else if (cmd.rem_wr) begin
      i_r <= i_plus1[IDX_W-1:0];
    end
    if (cmd.div_step) begin
      rnd_r  <= {rnd_r[RND_W-2:0], 1'b0};
      dcnt_r <= dcnt_r - {{(DC_W-1){1'b0}}, 1'b1};
      if (div_try >= {1'b0, count_r}) begin
        rem_r <= div_sub[IDX_W-1:0];
      end else begin
        rem_r <= div_try[IDX_W-1:0];
      end
    end
  end

  assign grow      = (action_r == ACT_INSERT) && !eq_r && (count_r < CAP_IDX);
  assign shrink    = (action_r == ACT_REMOVE) && eq_r;
  assign count_nxt = grow ? count_r + {{(IDX_W-1){1'b0}}, 1'b1} :
                     shrink ? count_r - {{(IDX_W-1){1'b0}}, 1'b1} : count_r;
  assign pos_ext    = {{POS_W{1'b0}}, (action_r == ACT_PICK) ? rem_r : lo_r};
  assign cnt_ext    = {{CNT_W{1'b0}}, count_nxt};
  assign picked_ext = {{PLACE_W{1'b0}}, rd_data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.fin;
      if (cmd.fin) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_count_after_r <= cnt_ext[CNT_W-1:0];
      if (action_r == ACT_PICK) begin
        out_found_r <= 1'b0;
        if (count_r == '0) begin
          out_position_r     <= '0;
          out_picked_place_r <= '0;
          out_status_r       <= ST_EMPTY;
        end else begin
          out_position_r     <= pos_ext[POS_W-1:0];
          out_picked_place_r <= picked_ext[PLACE_W-1:0];
          out_status_r       <= ST_OK;
        end
      end else begin
        out_found_r        <= eq_r;
        out_position_r     <= pos_ext[POS_W-1:0];
        out_picked_place_r <= '0;
        if (action_r == ACT_INSERT && !eq_r && count_r >= CAP_IDX) begin
          out_status_r <= ST_FULL;
        end else begin
          out_status_r <= ST_OK;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_position     = out_position_r;
  assign out_picked_place = out_picked_place_r;
  assign out_count_after  = out_count_after_r;
  assign out_status       = out_status_r;

endmodule
